FILE: src/sync_framed_packet_receiver_macros.svh
// Assertion macros for the sync framed packet receiver.
// No dependencies; included by sync_framed_packet_receiver, which carries the assertions.
`ifndef SYNC_FRAMED_PACKET_RECEIVER_MACROS_SVH
`define SYNC_FRAMED_PACKET_RECEIVER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SFPR_ASSERT_NOW(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define SFPR_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sfpr_pkg.sv
// Shared types and constants for the sync framed packet receiver.
// No dependencies; used by sfpr_step and sync_framed_packet_receiver.
package sfpr_pkg;

  localparam int TYPE_COUNT    = 8;
  localparam int HEADER_BYTES  = 2;
  localparam int TRAILER_BYTES = 2;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  localparam logic [2:0] PH_WAIT_AA  = 3'd0;
  localparam logic [2:0] PH_WAIT_55  = 3'd1;
  localparam logic [2:0] PH_TYPE     = 3'd2;
  localparam logic [2:0] PH_SIZE     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD  = 3'd4;
  localparam logic [2:0] PH_CHECK    = 3'd5;

  localparam logic [3:0] ST_UNSYNC       = 4'd0;
  localparam logic [3:0] ST_SYNC1        = 4'd1;
  localparam logic [3:0] ST_SYNC2        = 4'd2;
  localparam logic [3:0] ST_TYPE         = 4'd3;
  localparam logic [3:0] ST_UNKNOWN_TYPE = 4'd4;
  localparam logic [3:0] ST_BAD_SIZE     = 4'd5;
  localparam logic [3:0] ST_SIZE         = 4'd6;
  localparam logic [3:0] ST_PAYLOAD      = 4'd7;
  localparam logic [3:0] ST_PAYLOAD_DONE = 4'd8;
  localparam logic [3:0] ST_CHECK_OK     = 4'd9;
  localparam logic [3:0] ST_CHECK_ERR    = 4'd10;

  localparam logic [1:0] REG_INSTALLED_TYPES = 2'd0;
  localparam logic [1:0] REG_EXPECTED_SIZES  = 2'd1;
  localparam logic [1:0] REG_ANY_SIZE        = 2'd2;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] running_xor;
    logic [2:0] current_type;
    logic [8:0] bytes_left;
    logic [8:0] write_index;
  } state_t;

  typedef struct packed {
    logic [3:0] status;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [8:0] byte_index;
    logic [2:0] packet_type;
    logic       packet_good;
  } result_t;

endpackage

FILE: src/sfpr_step.sv
// Per-beat parser step: next framing state and result for one received byte.
// Depends on sfpr_pkg.
module sfpr_step (
  input  sfpr_pkg::state_t  cur,
  input  logic [7:0]        rx,
  input  logic [7:0]        installed_type_mask,
  input  logic [63:0]       expected_sizes,
  input  logic [7:0]        any_size_mask,
  output sfpr_pkg::state_t  nxt,
  output sfpr_pkg::result_t res
);
  import sfpr_pkg::*;

  logic [7:0] want;
  logic       any;
  logic [8:0] size_ext;
  logic       size_bad;

  assign want     = expected_sizes[{cur.current_type, 3'b000} +: 8];
  assign any      = any_size_mask[cur.current_type];
  assign size_ext = {1'b0, rx} + 9'(TRAILER_BYTES);
  assign size_bad = (!any && (want != rx)) || (size_ext <= 9'(HEADER_BYTES));

  always_comb begin
    nxt = cur;
    res = '0;
    case (cur.phase)
      PH_WAIT_55: begin
        if (rx == SYNC_SECOND) begin
          nxt.phase       = PH_TYPE;
          nxt.running_xor = '0;
          res.status      = ST_SYNC2;
        end else begin
          nxt.phase  = PH_WAIT_AA;
          res.status = ST_UNSYNC;
        end
      end
      PH_TYPE: begin
        nxt.running_xor = cur.running_xor ^ rx;
        if (rx >= 8'(TYPE_COUNT)) begin
          nxt.phase  = PH_WAIT_AA;
          res.status = ST_UNSYNC;
        end else begin
          nxt.current_type = rx[2:0];
          if (!installed_type_mask[rx[2:0]]) begin
            nxt.phase  = PH_WAIT_AA;
            res.status = ST_UNKNOWN_TYPE;
          end else begin
            nxt.phase      = PH_SIZE;
            res.status     = ST_TYPE;
            res.data_valid = 1'b1;
            res.data_byte  = rx;
          end
        end
      end
      PH_SIZE: begin
        if (size_bad) begin
          nxt.phase  = PH_WAIT_AA;
          res.status = ST_BAD_SIZE;
        end else begin
          nxt.running_xor = cur.running_xor ^ rx;
          nxt.bytes_left  = size_ext - 9'(HEADER_BYTES);
          nxt.write_index = 9'd2;
          nxt.phase       = PH_PAYLOAD;
          res.status      = ST_SIZE;
          res.data_valid  = 1'b1;
          res.data_byte   = rx;
          res.byte_index  = 9'd1;
        end
      end
      PH_PAYLOAD: begin
        nxt.running_xor = cur.running_xor ^ rx;
        res.data_valid  = 1'b1;
        res.data_byte   = rx;
        res.byte_index  = cur.write_index;
        nxt.write_index = cur.write_index + 9'd1;
        if (cur.bytes_left <= 9'd1) begin
          nxt.bytes_left = '0;
          nxt.phase      = PH_CHECK;
          res.status     = ST_PAYLOAD_DONE;
        end else begin
          nxt.bytes_left = cur.bytes_left - 9'd1;
          res.status     = ST_PAYLOAD;
        end
      end
      PH_CHECK: begin
        nxt.phase       = PH_WAIT_AA;
        nxt.write_index = '0;
        if (rx == cur.running_xor) begin
          res.status      = ST_CHECK_OK;
          res.packet_good = 1'b1;
        end else begin
          res.status = ST_CHECK_ERR;
        end
      end
      default: begin
        nxt.running_xor = '0;
        if (rx == SYNC_FIRST) begin
          nxt.phase  = PH_WAIT_55;
          res.status = ST_SYNC1;
        end else begin
          nxt.phase  = PH_WAIT_AA;
          res.status = ST_UNSYNC;
        end
      end
    endcase
    res.packet_type = nxt.current_type;
  end

endmodule

FILE: src/sync_framed_packet_receiver.sv
// Sync framed packet receiver: top level with beat registers and config registers.
// Depends on sfpr_pkg, sfpr_step and sync_framed_packet_receiver_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) takes one received byte a beat.
//   Output channel (out_valid / out_stall / status ... packet_good) gives exactly
//   one result beat for each input beat, in order.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   0 installed type mask, 1 expected sizes (byte t for type t), 2 any-size mask.
//   cfg_ready is always high; write only while the receiver is idle.
// Result path: input register, then one pass of the parser step into the output
//   register.
// Throughput: one byte per cycle while out_stall does not hold a full output register.
// Reset: rst empties both beat registers and clears the framing state and all config
//   registers; the receiver starts hunting for the sync pair.
// Stall: while out_stall holds a full output register, the parser step stops
//   and in_stall rises once the input register is also full.
`include "sync_framed_packet_receiver_macros.svh"

module sync_framed_packet_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic        data_valid,
  output logic [7:0]  data_byte,
  output logic [8:0]  byte_index,
  output logic [2:0]  packet_type,
  output logic        packet_good,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import sfpr_pkg::*;

  logic        in_full;
  logic [7:0]  in_byte;
  logic        advance;
  logic [7:0]  installed_type_mask;
  logic [63:0] expected_sizes;
  logic [7:0]  any_size_mask;
  state_t      state;
  state_t      state_next;
  result_t     step_res;
  result_t     result;

  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign cfg_ready = 1'b1;

  sfpr_step u_step (
    .cur                 (state),
    .rx                  (in_byte),
    .installed_type_mask (installed_type_mask),
    .expected_sizes      (expected_sizes),
    .any_size_mask       (any_size_mask),
    .nxt                 (state_next),
    .res                 (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      installed_type_mask <= '0;
      expected_sizes      <= '0;
      any_size_mask       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INSTALLED_TYPES: installed_type_mask <= cfg_data[7:0];
        REG_EXPECTED_SIZES:  expected_sizes      <= cfg_data;
        REG_ANY_SIZE:        any_size_mask       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
  end

  // framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_res;
    end
  end

  assign status      = result.status;
  assign data_valid  = result.data_valid;
  assign data_byte   = result.data_byte;
  assign byte_index  = result.byte_index;
  assign packet_type = result.packet_type;
  assign packet_good = result.packet_good;

  `SFPR_ASSERT_NOW(a_good_only_on_ok, clk, rst, out_valid && packet_good,
    status == ST_CHECK_OK, "packet_good without checksum ok")
  `SFPR_ASSERT_NOW(a_no_data_zero, clk, rst, out_valid && !data_valid,
    data_byte == 8'd0 && byte_index == 9'd0, "data fields set without data_valid")
  `SFPR_ASSERT_NOW(a_count_in_payload, clk, rst, state.phase != PH_PAYLOAD,
    state.bytes_left == 9'd0, "bytes left outside payload phase")
  `SFPR_ASSERT_NEXT(a_state_holds, clk, rst, !advance,
    $stable(state), "framing state moved without a beat")

endmodule
